/* src/contiguous_fit_allocator_macros.svh */
// Assertion macros for the contiguous fit allocator.
// Included by the top level; expects clk and rst_n in scope.
`ifndef CONTIGUOUS_FIT_ALLOCATOR_MACROS_SVH
`define CONTIGUOUS_FIT_ALLOCATOR_MACROS_SVH

// same-cycle implication
`define CFA_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CFA_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/cfa_pkg.sv */
// Package for the contiguous fit allocator: payload structs, codes,
// controller state type and controller/datapath command and status groups.
// No dependencies.
`timescale 1ns / 1ps

package cfa_pkg;

    // operation codes
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_ALLOC = 1'b1;

    // result status codes
    localparam logic [1:0] STATUS_LOADED = 2'd0;
    localparam logic [1:0] STATUS_ALLOC  = 2'd1;
    localparam logic [1:0] STATUS_NONE   = 2'd2;

    // fit strategy codes
    localparam logic [1:0] FIT_FIRST = 2'd0;
    localparam logic [1:0] FIT_BEST  = 2'd1;
    localparam logic [1:0] FIT_WORST = 2'd2;

    // register index, taken from paddr[2]
    localparam logic CFG_IDX_STRATEGY = 1'b0;
    localparam logic CFG_IDX_ACTIVE   = 1'b1;

    localparam logic [1:0] STRATEGY_RESET = FIT_FIRST;
    localparam logic [4:0] ACTIVE_RESET   = 5'd16;

    typedef struct packed {
        logic        operation;
        logic [3:0]  block_index;
        logic [15:0] size_value;
    } req_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  chosen_block;
        logic [15:0] remaining_size;
    } rsp_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_SCAN,
        ST_DRAIN,
        ST_UPDATE,
        ST_RESULT
    } cfa_state_t;

    typedef struct packed {
        logic capture;     // latch the accepted beat
        logic load_wr;     // write a load item into the table
        logic scan_start;  // clear the scan pointer
        logic scan_rd;     // read the entry at the scan pointer and advance
        logic upd_wr;      // write back the chosen block
        logic res_load;    // move the result into the output register
    } cfa_cmd_t;

    typedef struct packed {
        logic out_free;
        logic scan_last;
        logic count_zero;
    } cfa_stat_t;

endpackage

/* src/contiguous_fit_allocator.sv */
// Load beat: table write, then result. Allocate beat: one table read per scanned
// block (count = min(active_blocks, NUM_BLOCKS)), then drain, write-back and result;
// with no active blocks the scan and drain are skipped. One item at a time; the next
// beat is taken while the result waits in the output register.
// Reset: first fit, 16 active blocks, valid bits cleared so the table reads zero.
`timescale 1ns / 1ps
`include "contiguous_fit_allocator_macros.svh"

module contiguous_fit_allocator #(
    parameter int NUM_BLOCKS = 16,
    parameter int SIZE_BITS  = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               req_valid,
    output logic               req_ready,
    input  cfa_pkg::req_item_t req,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output cfa_pkg::rsp_item_t rsp
);

    import cfa_pkg::*;

    localparam int IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;

    logic [1:0] strategy_reg;
    logic [4:0] active_reg;
    logic       cfg_wr;

    cfa_cmd_t   cmd;
    cfa_stat_t  stat;

    logic                 ram_we;
    logic [IDX_W-1:0]     ram_waddr;
    logic [SIZE_BITS-1:0] ram_wdata;
    logic [IDX_W-1:0]     ram_raddr;
    logic [SIZE_BITS-1:0] ram_rdata;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strategy_reg <= STRATEGY_RESET;
            active_reg   <= ACTIVE_RESET;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == CFG_IDX_ACTIVE)
            begin
                active_reg <= pwdata[4:0];
            end
            else
            begin
                strategy_reg <= pwdata[1:0];
            end
        end
    end

    assign prdata = (paddr[2] == CFG_IDX_ACTIVE) ? {27'd0, active_reg}
                                                 : {30'd0, strategy_reg};

    cfa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .operation (req.operation),
        .stat      (stat),
        .cmd       (cmd)
    );

    cfa_datapath #(
        .NUM_BLOCKS (NUM_BLOCKS),
        .SIZE_BITS  (SIZE_BITS),
        .IDX_W      (IDX_W)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .strategy      (strategy_reg),
        .active_blocks (active_reg),
        .req           (req),
        .cmd           (cmd),
        .stat          (stat),
        .rsp_valid     (rsp_valid),
        .rsp_ready     (rsp_ready),
        .rsp           (rsp),
        .ram_we        (ram_we),
        .ram_waddr     (ram_waddr),
        .ram_wdata     (ram_wdata),
        .ram_raddr     (ram_raddr),
        .ram_rdata     (ram_rdata)
    );

    cfa_ram #(
        .WIDTH (SIZE_BITS),
        .DEPTH (NUM_BLOCKS),
        .AW    (IDX_W)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // one item at a time
    `CFA_ASSERT_NXT(a_one_item, req_valid && req_ready, !req_ready, "beat taken while busy")
    // the table is never written during a scan
    `CFA_ASSERT_IMP(a_no_wr_in_scan, cmd.scan_rd, !ram_we, "table write during scan")
    // a pending result is never overwritten
    `CFA_ASSERT_IMP(a_no_overwrite, cmd.res_load, !rsp_valid || rsp_ready, "result overwritten")
    // a refused request carries no block and no size
    `CFA_ASSERT_IMP(a_none_zero, rsp_valid && rsp.status == STATUS_NONE,
        rsp.chosen_block == 4'd0 && rsp.remaining_size == 16'd0, "refusal carries data")

endmodule

/* src/cfa_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module cfa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* src/cfa_ctrl.sv */
// Sequencer for the contiguous fit allocator: load, scan, drain, update, result.
// Depends on cfa_pkg.
`timescale 1ns / 1ps

module cfa_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  logic              operation,
    input  cfa_pkg::cfa_stat_t stat,
    output cfa_pkg::cfa_cmd_t  cmd
);

    import cfa_pkg::*;

    cfa_state_t state_reg;
    cfa_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    if (operation == OP_LOAD)
                    begin
                        state_next = ST_LOAD;
                    end
                    else if (stat.count_zero)
                    begin
                        state_next = ST_UPDATE;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_LOAD:   state_next = ST_RESULT;
            ST_SCAN:
            begin
                if (stat.scan_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:  state_next = ST_UPDATE;
            ST_UPDATE: state_next = ST_RESULT;
            ST_RESULT:
            begin
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        req_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                req_ready      = 1'b1;
                cmd.capture    = req_valid;
                cmd.scan_start = req_valid;
            end
            ST_LOAD:   cmd.load_wr  = 1'b1;
            ST_SCAN:   cmd.scan_rd  = 1'b1;
            ST_DRAIN:  cmd          = '0;
            ST_UPDATE: cmd.upd_wr   = 1'b1;
            ST_RESULT: cmd.res_load = stat.out_free;
            default:   cmd          = '0;
        endcase
    end

endmodule

/* src/cfa_datapath.sv */
// Datapath for the contiguous fit allocator: item registers, scan pointer,
// fit compare, valid bits, table write port and output register.
// Depends on cfa_pkg; drives an external cfa_ram.
`timescale 1ns / 1ps

module cfa_datapath #(
    parameter int NUM_BLOCKS = 16,
    parameter int SIZE_BITS  = 16,
    parameter int IDX_W      = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [1:0]            strategy,
    input  logic [4:0]            active_blocks,
    input  cfa_pkg::req_item_t    req,
    input  cfa_pkg::cfa_cmd_t     cmd,
    output cfa_pkg::cfa_stat_t    stat,
    output logic                  rsp_valid,
    input  logic                  rsp_ready,
    output cfa_pkg::rsp_item_t    rsp,
    output logic                  ram_we,
    output logic [IDX_W-1:0]      ram_waddr,
    output logic [SIZE_BITS-1:0]  ram_wdata,
    output logic [IDX_W-1:0]      ram_raddr,
    input  logic [SIZE_BITS-1:0]  ram_rdata
);

    import cfa_pkg::*;

    localparam int CNT_W = $clog2(NUM_BLOCKS + 1);

    // item registers
    logic                 op_reg;
    logic [3:0]           idx_reg;
    logic [SIZE_BITS-1:0] size_reg;

    // scan state
    logic [IDX_W-1:0]     scan_reg;
    logic                 rd_pend_reg;
    logic [IDX_W-1:0]     rd_idx_reg;
    logic                 rd_vld_reg;
    logic                 found_reg;
    logic [IDX_W-1:0]     pick_reg;
    logic [SIZE_BITS-1:0] best_reg;

    logic [NUM_BLOCKS-1:0] valid_reg;

    logic                 rsp_valid_reg;
    rsp_item_t            rsp_reg;
    rsp_item_t            rsp_next;

    logic [CNT_W-1:0]     count;
    logic                 in_range;
    logic [SIZE_BITS-1:0] scan_f;
    logic                 adequate;
    logic                 take;
    logic [SIZE_BITS-1:0] diff;

    assign count = (32'(active_blocks) > 32'(NUM_BLOCKS)) ? CNT_W'(NUM_BLOCKS)
                                                           : CNT_W'(active_blocks);
    assign in_range = (32'(idx_reg) < 32'(NUM_BLOCKS));
    assign diff     = best_reg - size_reg;

    assign stat.count_zero = (active_blocks == 5'd0);
    assign stat.scan_last  = (CNT_W'(scan_reg) + CNT_W'(1)) == count;
    assign stat.out_free   = !rsp_valid_reg || rsp_ready;

    // an entry never written since reset reads as zero
    assign scan_f   = rd_vld_reg ? ram_rdata : '0;
    assign adequate = (scan_f >= size_reg);

    always_comb
    begin
        case (strategy)
            FIT_FIRST: take = !found_reg;
            FIT_BEST:  take = !found_reg || (scan_f < best_reg);
            FIT_WORST: take = !found_reg || (scan_f > best_reg);
            default:   take = 1'b0;
        endcase
    end

    // table write port: load item or write-back of the chosen block
    assign ram_we    = (cmd.load_wr && in_range) || (cmd.upd_wr && found_reg);
    assign ram_waddr = cmd.load_wr ? IDX_W'(idx_reg) : pick_reg;
    assign ram_wdata = cmd.load_wr ? size_reg : diff;
    assign ram_raddr = scan_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg   <= req.operation;
            idx_reg  <= req.block_index;
            size_reg <= SIZE_BITS'(req.size_value);
        end
        if (cmd.scan_rd)
        begin
            rd_idx_reg <= scan_reg;
            rd_vld_reg <= valid_reg[scan_reg];
        end
        if (rd_pend_reg && adequate && take)
        begin
            pick_reg <= rd_idx_reg;
            best_reg <= scan_f;
        end
        if (cmd.res_load)
        begin
            rsp_reg <= rsp_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_reg      <= '0;
            rd_pend_reg   <= 1'b0;
            found_reg     <= 1'b0;
            valid_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rd_pend_reg <= cmd.scan_rd;
            if (cmd.scan_start)
            begin
                scan_reg <= '0;
            end
            else if (cmd.scan_rd)
            begin
                scan_reg <= scan_reg + IDX_W'(1);
            end
            if (cmd.capture)
            begin
                found_reg <= 1'b0;
            end
            else if (rd_pend_reg && adequate && take)
            begin
                found_reg <= 1'b1;
            end
            if (ram_we)
            begin
                valid_reg[ram_waddr] <= 1'b1;
            end
            if (cmd.res_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        if (op_reg == OP_LOAD)
        begin
            rsp_next.status         = STATUS_LOADED;
            rsp_next.chosen_block   = idx_reg;
            rsp_next.remaining_size = in_range ? 16'(size_reg) : 16'd0;
        end
        else if (found_reg)
        begin
            rsp_next.status         = STATUS_ALLOC;
            rsp_next.chosen_block   = 4'(pick_reg);
            rsp_next.remaining_size = 16'(diff);
        end
        else
        begin
            rsp_next.status         = STATUS_NONE;
            rsp_next.chosen_block   = 4'd0;
            rsp_next.remaining_size = 16'd0;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

/* tb/sv/cfa_checker.sv */
// Result checker for the contiguous fit allocator: tracks the free-size table
// and the two registers, predicts every result beat and compares it.
// Depends on cfa_pkg for the payload structs and codes.
`timescale 1ns / 1ps

module cfa_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    input  logic               pready,
    input  logic               req_valid,
    input  logic               req_ready,
    input  cfa_pkg::req_item_t req,
    input  logic               rsp_valid,
    input  logic               rsp_ready,
    input  cfa_pkg::rsp_item_t rsp,
    output int                 fail_count,
    output int                 outstanding,
    output int                 granted,
    output int                 refused
);

    import cfa_pkg::*;

    localparam int TABLE_DEPTH = 16;

    logic [15:0] free_size [TABLE_DEPTH];
    logic [1:0]  strategy;
    logic [4:0]  active;
    rsp_item_t   owed_results [$];

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("%0t MISMATCH %s: got %0d, expected %0d", $realtime, what, got, want);
        fail_count++;
    endtask

    // Applies one request beat to the shadow table and returns its result.
    function automatic rsp_item_t fit_outcome(req_item_t item);
        rsp_item_t   res;
        int unsigned span;
        int unsigned pick;
        bit          found;
        logic [15:0] need;
        res  = '0;
        need = item.size_value;
        if (item.operation == OP_LOAD) begin
            free_size[item.block_index] = need;
            res.status         = STATUS_LOADED;
            res.chosen_block   = item.block_index;
            res.remaining_size = need;
            return res;
        end
        // register values above the table depth saturate
        span  = (active > TABLE_DEPTH) ? TABLE_DEPTH : active;
        pick  = 0;
        found = 1'b0;
        for (int j = 0; j < span; j++) begin
            if (free_size[j] >= need) begin
                case (strategy)
                    FIT_FIRST:
                    begin
                        if (!found) begin
                            pick  = j;
                            found = 1'b1;
                        end
                    end
                    FIT_BEST:
                    begin
                        if (!found || free_size[j] < free_size[pick]) begin
                            pick  = j;
                            found = 1'b1;
                        end
                    end
                    FIT_WORST:
                    begin
                        if (!found || free_size[j] > free_size[pick]) begin
                            pick  = j;
                            found = 1'b1;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
        if (found) begin
            free_size[pick]    = free_size[pick] - need;
            res.status         = STATUS_ALLOC;
            res.chosen_block   = pick[3:0];
            res.remaining_size = free_size[pick];
        end
        else begin
            res.status = STATUS_NONE;
        end
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        rsp_item_t want;
        if (!rst_n) begin
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                free_size[i] = '0;
            end
            strategy = STRATEGY_RESET;
            active   = ACTIVE_RESET;
            owed_results.delete();
            granted  = 0;
            refused  = 0;
        end
        else begin
            // result side first so a beat accepted this edge never matches itself
            if (rsp_valid && rsp_ready) begin
                if (owed_results.size() == 0) begin
                    report_mismatch("result beat with nothing owed", 32'(rsp), 32'd0);
                end
                else begin
                    want = owed_results.pop_front();
                    if (rsp.status != want.status) begin
                        report_mismatch("status", 32'(rsp.status), 32'(want.status));
                    end
                    if (rsp.chosen_block != want.chosen_block) begin
                        report_mismatch("chosen_block", 32'(rsp.chosen_block),
                                        32'(want.chosen_block));
                    end
                    if (rsp.remaining_size != want.remaining_size) begin
                        report_mismatch("remaining_size", 32'(rsp.remaining_size),
                                        32'(want.remaining_size));
                    end
                    if (want.status == STATUS_ALLOC) begin
                        granted++;
                    end
                    else if (want.status == STATUS_NONE) begin
                        refused++;
                    end
                end
            end
            if (req_valid && req_ready) begin
                owed_results.push_back(fit_outcome(req));
            end
            if (psel && penable && pwrite && pready) begin
                if (paddr[2] == CFG_IDX_STRATEGY) begin
                    strategy = pwdata[1:0];
                end
                else begin
                    active = pwdata[4:0];
                end
            end
        end
        outstanding = owed_results.size();
    end

endmodule

/* tb/sv/tb.sv */
// Top of the contiguous fit allocator bench: clock, reset, register writes,
// request beats under varied idle mixes, and the verdict.
// Depends on cfa_pkg, contiguous_fit_allocator and cfa_checker.
`timescale 1ns / 1ps

module tb;
    import cfa_pkg::*;

    localparam int LIMIT_CYCLES  = 400000;
    localparam int SETTLE_CYCLES = 24;
    localparam int RAND_PHASES   = 16;
    localparam int RAND_PER_PASS = 74;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        psel      = 1'b0;
    logic        penable   = 1'b0;
    logic        pwrite    = 1'b0;
    logic [2:0]  paddr     = '0;
    logic [31:0] pwdata    = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        req_valid = 1'b0;
    logic        req_ready;
    req_item_t   req       = '0;
    logic        rsp_valid;
    logic        rsp_ready = 1'b0;
    rsp_item_t   rsp;

    int fail_count;
    int outstanding;
    int granted;
    int refused;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int beats_sent     = 0;
    int settings_done  = 0;
    int cycle_count    = 0;

    contiguous_fit_allocator u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    cfa_checker u_chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .pready      (pready),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .req         (req),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .rsp         (rsp),
        .fail_count  (fail_count),
        .outstanding (outstanding),
        .granted     (granted),
        .refused     (refused)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("contiguous_fit_allocator verification failed");
            $finish;
        end
    end

    function automatic req_item_t mk_item(logic op, logic [3:0] idx, logic [15:0] size);
        req_item_t it;
        it.operation   = op;
        it.block_index = idx;
        it.size_value  = size;
        return it;
    endfunction

    function automatic logic [15:0] load_size();
        int r;
        r = $urandom_range(99);
        if (r < 10) return 16'h0000;
        if (r < 20) return 16'hFFFF;
        if (r < 40) return 16'($urandom);
        return 16'($urandom_range(2000, 100));
    endfunction

    function automatic req_item_t random_item();
        req_item_t it;
        int        r;
        it.operation   = ($urandom_range(99) < 30) ? OP_LOAD : OP_ALLOC;
        it.block_index = 4'($urandom_range(15));
        if (it.operation == OP_LOAD) begin
            it.size_value = load_size();
        end
        else begin
            r = $urandom_range(99);
            if (r < 10)      it.size_value = 16'h0000;
            else if (r < 15) it.size_value = 16'hFFFF;
            else if (r < 35) it.size_value = 16'($urandom);
            else             it.size_value = 16'($urandom_range(300, 1));
        end
        return it;
    endfunction

    // Drops valid and holds off until every owed result is back, plus settle time.
    task automatic wait_drained();
        req_valid <= 1'b0;
        do @(negedge clk); while (outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_write(input logic idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apply_setting(input logic [31:0] strat, input logic [31:0] act);
        wait_drained();
        cfg_write(CFG_IDX_STRATEGY, strat);
        cfg_write(CFG_IDX_ACTIVE, act);
        settings_done++;
    endtask

    // Valid stays high across back-to-back beats; it only drops for an idle gap or a drain.
    task automatic send_item(input req_item_t it);
        while ($urandom_range(99) < send_idle_pct) begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= it;
        @(posedge clk);
        while (!req_ready) @(posedge clk);
        beats_sent++;
    endtask

    initial
    begin
        logic [31:0] strat;
        logic [31:0] act;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset setting: first fit over all blocks
        send_item(mk_item(OP_LOAD, 4'd0, 16'd100));
        send_item(mk_item(OP_LOAD, 4'd1, 16'd50));
        send_item(mk_item(OP_LOAD, 4'd2, 16'd50));
        send_item(mk_item(OP_LOAD, 4'd3, 16'd200));
        send_item(mk_item(OP_LOAD, 4'd15, 16'hFFFF));
        send_item(mk_item(OP_LOAD, 4'd14, 16'h0000));
        send_item(mk_item(OP_ALLOC, 4'd9, 16'd0));
        send_item(mk_item(OP_ALLOC, 4'd15, 16'd50));
        send_item(mk_item(OP_ALLOC, 4'd0, 16'hFFFF));
        send_item(mk_item(OP_ALLOC, 4'd7, 16'hFFFF));
        // best fit with a three-way tie
        apply_setting(32'(FIT_BEST), 32'd16);
        send_item(mk_item(OP_ALLOC, 4'd0, 16'd50));
        send_item(mk_item(OP_ALLOC, 4'd0, 16'd1));
        // worst fit over a short window
        apply_setting(32'(FIT_WORST), 32'd4);
        send_item(mk_item(OP_ALLOC, 4'd0, 16'd10));
        // unused strategy code refuses everything
        apply_setting(32'd3, 32'd16);
        send_item(mk_item(OP_ALLOC, 4'd0, 16'd0));
        // empty window
        apply_setting(32'(FIT_FIRST), 32'd0);
        send_item(mk_item(OP_ALLOC, 4'd0, 16'd0));
        // oversized window saturates
        apply_setting(32'(FIT_WORST), 32'd31);
        send_item(mk_item(OP_LOAD, 4'd15, 16'd1000));
        send_item(mk_item(OP_ALLOC, 4'd3, 16'd5));
        // single block; load lands outside the window
        apply_setting(32'(FIT_BEST), 32'd1);
        send_item(mk_item(OP_ALLOC, 4'd0, 16'd0));
        send_item(mk_item(OP_LOAD, 4'd5, 16'd7));

        for (int p = 0; p < RAND_PHASES; p++) begin
            strat = (p < 12) ? 32'(p % 3) : 32'($urandom_range(3));
            case (p)
                0:       act = 16;
                1:       act = 1;
                2:       act = 31;
                3:       act = 2;
                4:       act = 0;
                5:       act = 17;
                default: act = $urandom_range(16, 1);
            endcase
            case (p % 4)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 48;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 48;
                end
                default:
                begin
                    send_idle_pct  = 14;
                    recv_stall_pct = 14;
                end
            endcase
            apply_setting(strat, act);
            // refill the whole table so allocations have something to chew on
            for (int b = 0; b < 16; b++) begin
                send_item(mk_item(OP_LOAD, 4'(b), load_size()));
            end
            for (int k = 0; k < RAND_PER_PASS; k++) begin
                if (p % 5 == 2 && k == RAND_PER_PASS / 2) begin
                    wait_drained();
                end
                send_item(random_item());
            end
        end

        wait_drained();
        $display("run covered %0d request beats under %0d register settings",
                 beats_sent, settings_done);
        $display("allocations granted %0d, refused %0d, across four idle mixes",
                 granted, refused);
        if (fail_count == 0) begin
            $display("contiguous_fit_allocator verification clean");
        end
        else begin
            $display("contiguous_fit_allocator verification failed");
        end
        $finish;
    end

endmodule
